### rtl/core/bpww_pkg.sv
package bpww_pkg;

  // character codes
  localparam logic [7:0] CHAR_NL   = 8'd10;
  localparam logic [7:0] CHAR_SP   = 8'd32;
  localparam logic [7:0] CHAR_LO_A = 8'd97;
  localparam logic [7:0] CHAR_LO_J = 8'd106;

  // column setting bounds and register reset values
  localparam logic [4:0] COL_MIN       = 5'd8;
  localparam logic [4:0] COL_MAX       = 5'd29;
  localparam logic [4:0] COLS_RESET    = 5'd29;
  localparam logic [7:0] CAP_RESET     = 8'd124;
  localparam logic [7:0] NUMERAL_RESET = 8'd35;

  // register indexes on the configuration port
  localparam logic [1:0] REG_COLS    = 2'd0;
  localparam logic [1:0] REG_CAP     = 2'd1;
  localparam logic [1:0] REG_NUMERAL = 2'd2;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_SEP  = 2'd1,
    CMD_END  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [4:0] cols;
    logic [7:0] cap;
    logic [7:0] numeral;
  } cfg_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'd65) && (c <= 8'd90);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  // digits 1..9 become a..i, 0 becomes j, anything else is kept
  function automatic logic [7:0] digit_letter(input logic [7:0] c);
    logic [7:0] r;
    if (c == 8'd48) begin
      r = CHAR_LO_J;
    end else if (is_digit(c)) begin
      r = CHAR_LO_A + (c - 8'd49);
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [4:0] clamp_cols(input logic [4:0] v);
    logic [4:0] r;
    if (v < COL_MIN) begin
      r = COL_MIN;
    end else if (v > COL_MAX) begin
      r = COL_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/core/braille_prefix_word_wrapper_unit.sv
// grade-1 braille word wrapper
// input channel: push a text byte (in_text_char) or an end marker (in_end_of_text)
//   while full is low; the request is taken into a two-entry command queue
// result channel: while empty is low, out_char/out_last_out show the oldest
//   output byte; pop takes it. out_last_out marks the final byte of an end request
// a plain character is written into the word memory; bytes past WORD_MAX are dropped
// a separator ends the word: the back end writes marks, the word and a space into
//   the line memory at one byte per cycle; when the word does not fit, a newline
//   and the held line go out first; a line-memory read is issued only while the
//   result queue has room for it
// an end request finishes the pending word and then flushes the line the same way
// when the receiver stalls the two-entry result queue fills, the back end holds,
//   then the command queue fills and full rises; nothing is dropped
// reset (rst_n low, synchronous) empties both queues, the pending word and the
//   line, and loads the registers with their defaults; the memories keep stale
//   contents that are never read before being written
// registers: 0 line columns (clamped to 8..29), 1 capital mark, 2 numeral mark
module braille_prefix_word_wrapper_unit #(
  parameter int WORD_MAX   = 24,
  parameter int LINE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_text_char,
  input  logic        in_end_of_text,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char,
  output logic        out_last_out,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import bpww_pkg::*;

  cfg_t       cfg_r;
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_pop;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  // register file, written on the access cycle of a write request
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cols    <= COLS_RESET;
      cfg_r.cap     <= CAP_RESET;
      cfg_r.numeral <= NUMERAL_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COLS:    cfg_r.cols    <= clamp_cols(pwdata[4:0]);
        REG_CAP:     cfg_r.cap     <= pwdata[7:0];
        REG_NUMERAL: cfg_r.numeral <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLS:    prdata = {27'd0, cfg_r.cols};
      REG_CAP:     prdata = {24'd0, cfg_r.cap};
      REG_NUMERAL: prdata = {24'd0, cfg_r.numeral};
      default:     prdata = 32'd0;
    endcase
  end

  // front end: classify each byte and queue it
  bpww_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .text_char   (in_text_char),
    .end_of_text (in_end_of_text),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // back end: word and line memories, transform, wrap and line output
  bpww_back #(
    .WORD_MAX   (WORD_MAX),
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg_r),
    .out_empty (empty),
    .out_pop   (pop),
    .out_char  (out_char),
    .out_last  (out_last_out)
  );

endmodule

### rtl/core/bpww_ram.sv
module bpww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/core/bpww_front.sv
module bpww_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     text_char,
  input  logic           end_of_text,
  output logic           cmd_valid,
  output bpww_pkg::cmd_t cmd,
  input  logic           cmd_pop
);

  import bpww_pkg::*;

  cmd_t       q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       do_push, do_pop;

  // classify the incoming byte
  always_comb begin
    cls.ch = text_char;
    if (end_of_text) begin
      cls.kind = CMD_END;
    end else if (is_space(text_char)) begin
      cls.kind = CMD_SEP;
    end else begin
      cls.kind = CMD_CHAR;
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/core/bpww_back.sv
module bpww_back #(
  parameter int WORD_MAX   = 24,
  parameter int LINE_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  bpww_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  bpww_pkg::cfg_t cfg,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_char,
  output logic           out_last
);

  import bpww_pkg::*;

  localparam int WL_W = $clog2(WORD_MAX + 1);
  localparam int WA_W = $clog2(WORD_MAX);
  localparam int LD_W = $clog2(LINE_DEPTH + 1);
  localparam int LA_W = $clog2(LINE_DEPTH);
  localparam int SW   = LD_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_NL   = 6'b000010,
    ST_LINE = 6'b000100,
    ST_PFX  = 6'b001000,
    ST_BODY = 6'b010000,
    ST_SPC  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [WL_W-1:0] wl_r, wl_nxt;
  logic [LD_W-1:0] line_len_r, line_len_nxt;
  logic [LD_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [LD_W-1:0] ln_idx_r, ln_idx_nxt;
  logic            ln_vld_r, ln_vld_nxt;
  logic            ln_last_r, ln_last_nxt;
  logic [WL_W-1:0] rd_idx_r, rd_idx_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [7:0]      c0_r, c0_nxt;
  logic [7:0]      c1_r, c1_nxt;
  logic [1:0]      pfx_left_r, pfx_left_nxt;
  logic            num_word_r, num_word_nxt;
  logic            final_r, final_nxt;
  logic            end_pend_r, end_pend_nxt;

  logic            w_we;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [7:0]      w_wdata, w_rdata;
  logic            l_we;
  logic [LA_W-1:0] l_waddr, l_raddr;
  logic [7:0]      l_wdata, l_rdata;

  logic [1:0]      pfx_cnt;
  logic            is_num;
  logic [SW-1:0]   word_n, line_sum;
  logic            fits;

  logic [7:0]      oq_ch_r [2];
  logic            oq_last_r [2];
  logic            oq_wr_r, oq_rd_r;
  logic [1:0]      oq_cnt_r;
  logic            push, push_last, do_pop;
  logic [7:0]      push_ch;

  bpww_ram #(.WIDTH(8), .DEPTH(WORD_MAX)) u_word_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  bpww_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  // word transform from the two leading characters
  always_comb begin
    is_num  = is_digit(c0_r);
    pfx_cnt = 2'd0;
    if (is_num) begin
      pfx_cnt = 2'd1;
    end else if (is_upper(c0_r)) begin
      pfx_cnt = (is_upper(c1_r) && (wl_r > WL_W'(1))) ? 2'd2 : 2'd1;
    end
    word_n   = SW'(pfx_cnt) + SW'(wl_r) + SW'(1);
    line_sum = SW'(line_len_r) + word_n;
    fits     = (line_sum < SW'(cfg.cols)) && (line_sum <= SW'(LINE_DEPTH));
  end

  always_comb begin
    state_nxt    = state_r;
    wl_nxt       = wl_r;
    line_len_nxt = line_len_r;
    wr_ptr_nxt   = wr_ptr_r;
    ln_idx_nxt   = ln_idx_r;
    ln_vld_nxt   = 1'b0;
    ln_last_nxt  = ln_last_r;
    rd_idx_nxt   = rd_idx_r;
    rd_vld_nxt   = 1'b0;
    c0_nxt       = c0_r;
    c1_nxt       = c1_r;
    pfx_left_nxt = pfx_left_r;
    num_word_nxt = num_word_r;
    final_nxt    = final_r;
    end_pend_nxt = end_pend_r;
    cmd_pop      = 1'b0;
    w_we         = 1'b0;
    w_waddr      = wl_r[WA_W-1:0];
    w_wdata      = cmd.ch;
    w_raddr      = rd_idx_r[WA_W-1:0];
    l_we         = 1'b0;
    l_waddr      = wr_ptr_r[LA_W-1:0];
    l_wdata      = CHAR_SP;
    l_raddr      = ln_idx_r[LA_W-1:0];
    push         = 1'b0;
    push_ch      = CHAR_NL;
    push_last    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_CHAR: begin
              // bytes past the word limit are dropped
              if (wl_r < WL_W'(WORD_MAX)) begin
                w_we   = 1'b1;
                wl_nxt = wl_r + WL_W'(1);
                if (wl_r == '0) begin
                  c0_nxt = cmd.ch;
                end
                if (wl_r == WL_W'(1)) begin
                  c1_nxt = cmd.ch;
                end
              end
            end
            CMD_SEP, CMD_END: begin
              if (wl_r != '0) begin
                pfx_left_nxt = pfx_cnt;
                num_word_nxt = is_num;
                end_pend_nxt = (cmd.kind == CMD_END);
                if (fits) begin
                  wr_ptr_nxt = line_len_r;
                  state_nxt  = ST_PFX;
                end else begin
                  final_nxt = 1'b0;
                  state_nxt = ST_NL;
                end
              end else if (cmd.kind == CMD_END) begin
                final_nxt = 1'b1;
                state_nxt = ST_NL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_NL: begin
        if (oq_cnt_r != 2'd2) begin
          push       = 1'b1;
          push_ch    = CHAR_NL;
          push_last  = final_r && (line_len_r == '0);
          ln_idx_nxt = '0;
          state_nxt  = ST_LINE;
        end
      end
      ST_LINE: begin
        if (ln_vld_r) begin
          push      = 1'b1;
          push_ch   = l_rdata;
          push_last = ln_last_r;
        end
        if ((ln_idx_r < line_len_r) && ((oq_cnt_r + {1'b0, ln_vld_r}) < 2'd2)) begin
          ln_idx_nxt  = ln_idx_r + LD_W'(1);
          ln_vld_nxt  = 1'b1;
          ln_last_nxt = final_r && ((ln_idx_r + LD_W'(1)) == line_len_r);
        end else if ((ln_idx_r == line_len_r) && !ln_vld_r) begin
          if (final_r) begin
            line_len_nxt = '0;
            final_nxt    = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            wr_ptr_nxt = '0;
            state_nxt  = ST_PFX;
          end
        end
      end
      ST_PFX: begin
        if (pfx_left_r != 2'd0) begin
          l_we         = 1'b1;
          l_wdata      = num_word_r ? cfg.numeral : cfg.cap;
          wr_ptr_nxt   = wr_ptr_r + LD_W'(1);
          pfx_left_nxt = pfx_left_r - 2'd1;
        end else begin
          rd_idx_nxt = '0;
          state_nxt  = ST_BODY;
        end
      end
      ST_BODY: begin
        // word bytes stream one per cycle behind the registered read
        if (rd_vld_r) begin
          l_we       = 1'b1;
          l_wdata    = num_word_r ? digit_letter(w_rdata) : w_rdata;
          wr_ptr_nxt = wr_ptr_r + LD_W'(1);
        end
        if (rd_idx_r < wl_r) begin
          rd_idx_nxt = rd_idx_r + WL_W'(1);
          rd_vld_nxt = 1'b1;
        end else begin
          state_nxt = ST_SPC;
        end
      end
      ST_SPC: begin
        l_we         = 1'b1;
        l_wdata      = CHAR_SP;
        line_len_nxt = wr_ptr_r + LD_W'(1);
        wl_nxt       = '0;
        if (end_pend_r) begin
          end_pend_nxt = 1'b0;
          final_nxt    = 1'b1;
          state_nxt    = ST_NL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // two-entry result queue
  assign do_pop    = out_pop && (oq_cnt_r != 2'd0);
  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_char  = oq_ch_r[oq_rd_r];
  assign out_last  = oq_last_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      oq_ch_r[oq_wr_r]   <= push_ch;
      oq_last_r[oq_wr_r] <= push_last;
    end
    wr_ptr_r   <= wr_ptr_nxt;
    ln_idx_r   <= ln_idx_nxt;
    ln_last_r  <= ln_last_nxt;
    rd_idx_r   <= rd_idx_nxt;
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    pfx_left_r <= pfx_left_nxt;
    num_word_r <= num_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wl_r       <= '0;
      line_len_r <= '0;
      ln_vld_r   <= 1'b0;
      rd_vld_r   <= 1'b0;
      final_r    <= 1'b0;
      end_pend_r <= 1'b0;
      oq_wr_r    <= 1'b0;
      oq_rd_r    <= 1'b0;
      oq_cnt_r   <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      wl_r       <= wl_nxt;
      line_len_r <= line_len_nxt;
      ln_vld_r   <= ln_vld_nxt;
      rd_vld_r   <= rd_vld_nxt;
      final_r    <= final_nxt;
      end_pend_r <= end_pend_nxt;
      oq_wr_r    <= push ? ~oq_wr_r : oq_wr_r;
      oq_rd_r    <= do_pop ? ~oq_rd_r : oq_rd_r;
      oq_cnt_r   <= oq_cnt_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule
